// ===== rtl/ttd_pkg.sv =====
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared codes and controller/datapath interface types of the tag tree decoder.
// ----------------------------------------------------------------------------
package ttd_pkg;

    // item kinds (s_tuser)
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_BIT   = 2'd2;

    // result status (m_tuser)
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NEED = 2'd1;
    localparam logic [1:0] ST_REJ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        EM_DONE = 2'd0,
        EM_REJ  = 2'd1,
        EM_FIN  = 2'd2,
        EM_NEED = 2'd3
    } ttd_emit_t;

    typedef struct packed {
        logic      clr_start;
        logic      clr_step;
        logic      load_query;
        logic      load_bit;
        logic      top_step;
        logic      addr_start;
        logic      addr_leaf;
        logic      lev_dec;
        logic      addr_step;
        logic      addr_latch;
        logic      mem_rd;
        logic      eval;
        logic      eval_bit;
        logic      emit;
        ttd_emit_t emit_sel;
    } ttd_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic top_done;
        logic addr_done;
        logic need_bit;
        logic lev_zero;
        logic leaf_bad;
        logic out_busy;
    } ttd_sts_t;

endpackage

// ===== rtl/tag_tree_decoder.sv =====
// ----------------------------------------------------------------------------
// tag_tree_decoder
// Tag tree decoder: clear, leaf query and stream bit items over a node memory.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tuser kind, tdata col/row/limit/bit
// m_       out  m_tvalid/m_tready  tuser status, tdata included/leaf_value
// cfg_     in   cfg_we             cfg_addr index, cfg_wdata value
//
// After reset a sweep zeroes the node memory; no items are accepted meanwhile.
// A clear item runs the same sweep, then reports a done result. A query is
// accepted, finds the root level L, then per visited node at level k runs the
// address unit (it adds one level area per cycle), a node read and an
// evaluation, plus a leaf read when a bit is needed. A bit item runs the same
// per node. One item is in work at a time; a pending result blocks only s_tready.
// ----------------------------------------------------------------------------
module tag_tree_decoder import ttd_pkg::*; #(
    parameter int MAX_DIM    = 32,
    parameter int NODE_DEPTH = 2048,
    parameter int VALUE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // leaf_col[4:0] leaf_row[9:5] limit[25:10] stream_bit[26]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // included[0] leaf_value[16:1]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata
);

    ttd_cmd_t    cmd;
    ttd_sts_t    sts;
    logic        out_incl;
    logic [15:0] out_value;

    ttd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttd_datapath #(
        .MAX_DIM    (MAX_DIM),
        .NODE_DEPTH (NODE_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_col       (s_tdata[4:0]),
        .in_row       (s_tdata[9:5]),
        .in_limit     (s_tdata[25:10]),
        .in_bit       (s_tdata[26]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_status   (m_tuser),
        .out_included (out_incl),
        .out_value    (out_value)
    );

    assign m_tdata = {7'd0, out_value, out_incl};

endmodule

// ===== rtl/ttd_datapath.sv =====
// ----------------------------------------------------------------------------
// ttd_datapath
// Node memory, address unit, query registers and result register.
// ----------------------------------------------------------------------------
module ttd_datapath import ttd_pkg::*; #(
    parameter int MAX_DIM    = 32,
    parameter int NODE_DEPTH = 2048,
    parameter int VALUE_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ttd_cmd_t   cmd,
    output ttd_sts_t   sts,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [5:0] cfg_wdata,
    input  logic [4:0] in_col,
    input  logic [4:0] in_row,
    input  logic [15:0] in_limit,
    input  logic       in_bit,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [1:0] out_status,
    output logic       out_included,
    output logic [15:0] out_value
);

    localparam int VB       = VALUE_BITS;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int LVL_RAW  = $clog2($clog2(MAX_DIM) + 1);
    localparam int LVL_W    = (LVL_RAW > 0) ? LVL_RAW : 1;
    localparam int MEM_AW   = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int ADDR_RAW = $clog2(2 * MAX_DIM * MAX_DIM + 1);
    localparam int ADDR_W   = (ADDR_RAW > MEM_AW) ? ADDR_RAW : MEM_AW;
    localparam int PW       = DIM_W + 5;

    logic [5:0]        gw_reg, gh_reg;
    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [4:0]        col_reg, row_reg;
    logic [VB-1:0]     limit_reg, carried_reg;
    logic              bit_reg;
    logic [LVL_W-1:0]  lev_reg, tgt_reg, k_reg;
    logic [DIM_W-1:0]  aw_reg, ah_reg;
    logic [ADDR_W-1:0] base_reg, addr_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [2*VB-1:0]   mem [NODE_DEPTH];
    logic [2*VB-1:0]   rdata_reg;
    logic              out_valid_reg, out_incl_reg;
    logic [1:0]        out_status_reg;
    logic [15:0]       out_value_reg;

    logic [31:0]       lim32;
    logic [4:0]        col_sh, row_sh;
    logic [PW-1:0]     row_off;
    logic [2*DIM_W-1:0] area;
    logic              oob;
    logic [VB-1:0]     lo_r, v_r, lo_m, v_m, lo_e, v_e;
    logic              upd, need_bit, node_wr, wr_en;
    logic [MEM_AW-1:0] waddr;
    logic [2*VB-1:0]   wdata;
    logic [31:0]       fin32, leaf32;

    function automatic logic [DIM_W-1:0] halve_up(input logic [DIM_W-1:0] d);
        logic [DIM_W:0] s;
        s = {1'b0, d} + 1'b1;
        return s[DIM_W:1];
    endfunction

    // grid registers out of range clamp to 1..MAX_DIM
    always_comb begin
        if (gw_reg == 6'd0) eff_w = DIM_W'(1);
        else if (32'(gw_reg) > MAX_DIM) eff_w = DIM_W'(MAX_DIM);
        else eff_w = DIM_W'(gw_reg);
        if (gh_reg == 6'd0) eff_h = DIM_W'(1);
        else if (32'(gh_reg) > MAX_DIM) eff_h = DIM_W'(MAX_DIM);
        else eff_h = DIM_W'(gh_reg);
    end

    assign lim32   = 32'(in_limit);
    assign col_sh  = col_reg >> tgt_reg;
    assign row_sh  = row_reg >> tgt_reg;
    assign row_off = PW'(row_sh) * PW'(aw_reg);
    assign area    = (2*DIM_W)'(aw_reg) * (2*DIM_W)'(ah_reg);
    assign oob     = 32'(addr_reg) >= 32'(NODE_DEPTH);

    // node evaluation on the registered read word
    always_comb begin
        lo_r = oob ? '0 : rdata_reg[2*VB-1:VB];
        v_r  = oob ? '0 : rdata_reg[VB-1:0];
        lo_m = rdata_reg[2*VB-1:VB] + 1'b1;
        v_m  = rdata_reg[VB-1:0] + {{(VB-1){1'b0}}, ~bit_reg};
        upd  = lo_r < carried_reg;
        if (cmd.eval_bit) begin
            lo_e    = oob ? '0 : lo_m;
            v_e     = oob ? '0 : v_m;
            node_wr = !oob;
        end else begin
            lo_e    = upd ? carried_reg : lo_r;
            v_e     = upd ? carried_reg : v_r;
            node_wr = upd && !oob;
        end
        need_bit = (lo_e == v_e) && (lo_e < limit_reg);
    end

    assign wr_en = cmd.clr_step || (cmd.eval && node_wr);
    assign waddr = cmd.clr_step ? clr_cnt_reg : addr_reg[MEM_AW-1:0];
    assign wdata = cmd.clr_step ? '0 : (cmd.eval_bit ? {lo_m, v_m} : {lo_e, v_e});

    always_ff @(posedge aclk) begin
        if (wr_en) mem[waddr] <= wdata;
        if (cmd.mem_rd) rdata_reg <= mem[addr_reg[MEM_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg      <= 6'd1;
            gh_reg      <= 6'd1;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_we && cfg_addr == REG_GRID_WIDTH) gw_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == REG_GRID_HEIGHT) gh_reg <= cfg_wdata;
            if (cmd.clr_start) clr_cnt_reg <= '0;
            else if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            col_reg     <= in_col;
            row_reg     <= in_row;
            limit_reg   <= lim32[VB-1:0];
            carried_reg <= '0;
            lev_reg     <= '0;
            aw_reg      <= eff_w;
            ah_reg      <= eff_h;
        end else if (cmd.top_step) begin
            aw_reg  <= halve_up(aw_reg);
            ah_reg  <= halve_up(ah_reg);
            lev_reg <= lev_reg + 1'b1;
        end else if (cmd.addr_start) begin
            if (cmd.addr_leaf) tgt_reg <= '0;
            else if (cmd.lev_dec) tgt_reg <= lev_reg - 1'b1;
            else tgt_reg <= lev_reg;
            if (cmd.lev_dec) lev_reg <= lev_reg - 1'b1;
            k_reg    <= '0;
            base_reg <= '0;
            aw_reg   <= eff_w;
            ah_reg   <= eff_h;
        end else if (cmd.addr_step) begin
            base_reg <= base_reg + ADDR_W'(area);
            aw_reg   <= halve_up(aw_reg);
            ah_reg   <= halve_up(ah_reg);
            k_reg    <= k_reg + 1'b1;
        end
        if (cmd.addr_latch) addr_reg <= base_reg + ADDR_W'(row_off) + ADDR_W'(col_sh);
        if (cmd.load_bit) bit_reg <= in_bit;
        if (cmd.eval && !need_bit) carried_reg <= v_e;
    end

    assign fin32  = 32'(v_e);
    assign leaf32 = 32'(v_r);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            unique case (cmd.emit_sel)
                EM_DONE: begin
                    out_status_reg <= ST_DONE;
                    out_incl_reg   <= 1'b0;
                    out_value_reg  <= '0;
                end
                EM_REJ: begin
                    out_status_reg <= ST_REJ;
                    out_incl_reg   <= 1'b0;
                    out_value_reg  <= '0;
                end
                EM_FIN: begin
                    out_status_reg <= ST_DONE;
                    out_incl_reg   <= (lo_e != v_e);
                    out_value_reg  <= fin32[15:0];
                end
                EM_NEED: begin
                    out_status_reg <= ST_NEED;
                    out_incl_reg   <= 1'b0;
                    out_value_reg  <= leaf32[15:0];
                end
                default: begin
                    out_status_reg <= ST_REJ;
                    out_incl_reg   <= 1'b0;
                    out_value_reg  <= '0;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_included = out_incl_reg;
    assign out_value    = out_value_reg;

    always_comb begin
        sts.clr_done  = (clr_cnt_reg == MEM_AW'(NODE_DEPTH - 1));
        sts.top_done  = (aw_reg <= DIM_W'(1)) && (ah_reg <= DIM_W'(1));
        sts.addr_done = (k_reg == tgt_reg);
        sts.need_bit  = need_bit;
        sts.lev_zero  = (lev_reg == '0);
        sts.leaf_bad  = (32'(in_col) >= 32'(eff_w)) || (32'(in_row) >= 32'(eff_h));
        sts.out_busy  = out_valid_reg;
    end

    // nodes outside the memory are never written by a walk
    a_no_oob_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !cmd.clr_step) |-> !oob)
        else $error("node write beyond memory depth");

endmodule

// ===== rtl/ttd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttd_ctrl
// Sequencer for clear sweeps, root-to-leaf walks and stream bit updates.
// ----------------------------------------------------------------------------
module ttd_ctrl import ttd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_kind,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  ttd_sts_t   sts,
    output ttd_cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_TOP  = 7'b0000100,
        S_ADDR = 7'b0001000,
        S_RD   = 7'b0010000,
        S_EVAL = 7'b0100000,
        S_LEAF = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        M_ENTER = 2'd0,
        M_BIT   = 2'd1,
        M_LEAF  = 2'd2
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   active_reg, active_next;
    logic   clr_emit_reg, clr_emit_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE) && !sts.out_busy;
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        active_next   = active_reg;
        clr_emit_next = clr_emit_reg;
        cmd           = '0;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    cmd.emit     = clr_emit_reg;
                    cmd.emit_sel = EM_DONE;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (in_kind)
                        KIND_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            clr_emit_next = 1'b1;
                            active_next   = 1'b0;
                            state_next    = S_CLR;
                        end
                        KIND_QUERY: begin
                            if (active_reg || sts.leaf_bad) begin
                                cmd.emit     = 1'b1;
                                cmd.emit_sel = EM_REJ;
                            end else begin
                                cmd.load_query = 1'b1;
                                active_next    = 1'b1;
                                state_next     = S_TOP;
                            end
                        end
                        KIND_BIT: begin
                            if (active_reg) begin
                                cmd.load_bit   = 1'b1;
                                cmd.addr_start = 1'b1;
                                mode_next      = M_BIT;
                                state_next     = S_ADDR;
                            end else begin
                                cmd.emit     = 1'b1;
                                cmd.emit_sel = EM_REJ;
                            end
                        end
                        default: begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EM_REJ;
                        end
                    endcase
                end
            end
            S_TOP: begin
                if (sts.top_done) begin
                    cmd.addr_start = 1'b1;
                    mode_next      = M_ENTER;
                    state_next     = S_ADDR;
                end else begin
                    cmd.top_step = 1'b1;
                end
            end
            S_ADDR: begin
                if (sts.addr_done) begin
                    cmd.addr_latch = 1'b1;
                    state_next     = S_RD;
                end else begin
                    cmd.addr_step = 1'b1;
                end
            end
            S_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = (mode_reg == M_LEAF) ? S_LEAF : S_EVAL;
            end
            S_EVAL: begin
                cmd.eval     = 1'b1;
                cmd.eval_bit = (mode_reg == M_BIT);
                if (sts.need_bit) begin
                    // fetch the leaf for the reported value, then wait for a bit
                    cmd.addr_start = 1'b1;
                    cmd.addr_leaf  = 1'b1;
                    mode_next      = M_LEAF;
                    state_next     = S_ADDR;
                end else if (sts.lev_zero) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EM_FIN;
                    active_next  = 1'b0;
                    state_next   = S_IDLE;
                end else begin
                    cmd.addr_start = 1'b1;
                    cmd.lev_dec    = 1'b1;
                    mode_next      = M_ENTER;
                    state_next     = S_ADDR;
                end
            end
            S_LEAF: begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_NEED;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // a grid change invalidates any walk in progress
        if (cfg_we && (cfg_addr == REG_GRID_WIDTH || cfg_addr == REG_GRID_HEIGHT)) begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            mode_reg     <= M_ENTER;
            active_reg   <= 1'b0;
            clr_emit_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            active_reg   <= active_next;
            clr_emit_reg <= clr_emit_next;
        end
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !sts.out_busy)
        else $error("result overwritten before transfer");

    a_clear_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_kind == KIND_CLEAR) |=> (state_reg == S_CLR && !active_reg))
        else $error("clear did not start sweep");

    a_walk_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL && cmd.eval_bit) |-> (mode_reg == M_BIT))
        else $error("bit update outside bit mode");

endmodule
